// File: hdl/gpt_pkg.sv
// Guarded parameter table: shared types and constants.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
package gpt_pkg;

  // Request operations
  typedef enum logic [2:0] {
    MODE_LOAD  = 3'd0,
    MODE_WRITE = 3'd1,
    MODE_READ  = 3'd2,
    MODE_LIVE  = 3'd3,
    MODE_CLEAR = 3'd4
  } mode_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BLOCKED     = 3'd1,
    ST_POWER_RESET = 3'd2,
    ST_READ_ONLY   = 3'd3,
    ST_RANGE       = 3'd4,
    ST_BAD_CODE    = 3'd5
  } status_t;

  // Write rule, attribute bits [4:3]
  typedef enum logic [1:0] {
    RULE_FREE    = 2'b00,
    RULE_RUNLOCK = 2'b01,
    RULE_POWER   = 2'b10,
    RULE_RO      = 2'b11
  } rule_t;

  localparam int RULE_LSB = 3;
  localparam int RULE_MSB = 4;
  localparam logic [31:0] CHANGED_BIT   = 32'h0000_0100;
  localparam logic [31:0] CHANGED_CLEAR = 32'hFFFF_FEFF;

  // code / 100 as (code * 41944) >> 22, exact for all codes below 43699
  localparam logic [15:0] DIV100_MUL   = 16'd41944;
  localparam int          DIV100_SHIFT = 22;
  localparam int          GROUP_W      = 10;
  localparam int          INDEX_W      = 7;

  // Group numbers that select groups A to D
  localparam logic [GROUP_W-1:0] GRP_A_NUM = 10'd0;
  localparam logic [GROUP_W-1:0] GRP_B_NUM = 10'd50;
  localparam logic [GROUP_W-1:0] GRP_C_NUM = 10'd60;
  localparam logic [GROUP_W-1:0] GRP_D_NUM = 10'd100;

  // One stored entry
  typedef struct packed {
    logic [31:0] live;
    logic [31:0] pers;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] attr;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_LOOKUP = 2'd1,
    S_EXEC   = 2'd2
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic lookup;
    logic execute;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// File: hdl/gpt_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module gpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/gpt_ctrl.sv
// Guarded parameter table controller: accept / lookup / execute sequencing.
// Depends on gpt_pkg.
module gpt_ctrl
  import gpt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_LOOKUP;
      end
      S_LOOKUP: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.out_free) state_nxt = in_valid ? S_LOOKUP : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Outputs: a new request is taken while the previous one finishes
  always_comb begin
    in_ready    = 1'b0;
    cmd.lookup  = 1'b0;
    cmd.execute = 1'b0;
    unique case (state_r)
      S_IDLE:   in_ready = 1'b1;
      S_LOOKUP: cmd.lookup = 1'b1;
      S_EXEC: begin
        in_ready    = sts.out_free;
        cmd.execute = sts.out_free;
      end
      default: in_ready = 1'b0;
    endcase
    cmd.capture = in_valid && in_ready;
  end

endmodule

// File: hdl/gpt_dpath.sv
// Guarded parameter table datapath: code decode, entry RAM, guarded update,
// change counter and result register. Depends on gpt_pkg and gpt_ram.
module gpt_dpath
  import gpt_pkg::*;
#(
  parameter int GROUP_A_SIZE = 64,
  parameter int GROUP_B_SIZE = 64,
  parameter int GROUP_C_SIZE = 64,
  parameter int GROUP_D_SIZE = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [2:0]         in_mode,
  input  logic [15:0]        in_code,
  input  logic signed [31:0] in_new_value,
  input  logic signed [31:0] in_load_min,
  input  logic signed [31:0] in_load_max,
  input  logic [31:0]        in_load_attr,
  input  logic               in_mark_change,
  input  logic               in_drive_running,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic [31:0]        out_value,
  output logic signed [31:0] out_min,
  output logic signed [31:0] out_max,
  output logic [31:0]        out_attr,
  output logic [15:0]        out_change_count
);

  localparam int BASE_B = GROUP_A_SIZE;
  localparam int BASE_C = GROUP_A_SIZE + GROUP_B_SIZE;
  localparam int BASE_D = GROUP_A_SIZE + GROUP_B_SIZE + GROUP_C_SIZE;
  localparam int DEPTH  = BASE_D + GROUP_D_SIZE;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Captured request
  logic [2:0]         mode_r;
  logic [15:0]        code_r;
  logic signed [31:0] value_r;
  logic signed [31:0] lmin_r;
  logic signed [31:0] lmax_r;
  logic [31:0]        lattr_r;
  logic               mark_r;
  logic               run_r;
  logic [GROUP_W-1:0] group_r;
  logic [31:0]        div_prod;

  // Group number by reciprocal multiply, registered at capture
  assign div_prod = in_code * DIV100_MUL;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= in_mode;
      code_r  <= in_code;
      value_r <= in_new_value;
      lmin_r  <= in_load_min;
      lmax_r  <= in_load_max;
      lattr_r <= in_load_attr;
      mark_r  <= in_mark_change;
      run_r   <= in_drive_running;
      group_r <= div_prod[DIV100_SHIFT +: GROUP_W];
    end
  end

  // Index = code - 100 * group (shift-add), then slot and range check
  logic [15:0]        grp_x100;
  logic [15:0]        rem_full;
  logic [INDEX_W-1:0] index;
  logic [AW-1:0]      slot;
  logic               slot_ok;
  logic [AW-1:0]      slot_r;
  logic               ok_r;

  assign grp_x100 = (16'(group_r) << 6) + (16'(group_r) << 5) + (16'(group_r) << 2);
  assign rem_full = code_r - grp_x100;
  assign index    = rem_full[INDEX_W-1:0];

  always_comb begin
    slot    = '0;
    slot_ok = 1'b0;
    if (group_r == GRP_A_NUM) begin
      slot    = AW'(index);
      slot_ok = index < INDEX_W'(GROUP_A_SIZE);
    end else if (group_r == GRP_B_NUM) begin
      slot    = AW'(BASE_B) + AW'(index);
      slot_ok = index < INDEX_W'(GROUP_B_SIZE);
    end else if (group_r == GRP_C_NUM) begin
      slot    = AW'(BASE_C) + AW'(index);
      slot_ok = index < INDEX_W'(GROUP_C_SIZE);
    end else if (group_r == GRP_D_NUM) begin
      slot    = AW'(BASE_D) + AW'(index);
      slot_ok = index < INDEX_W'(GROUP_D_SIZE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      slot_r <= slot;
      ok_r   <= slot_ok;
    end
  end

  // Entry store
  entry_t rd_entry;
  entry_t entry_nxt;
  logic   wr_en;

  gpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (cmd.execute && wr_en),
    .waddr (slot_r),
    .wdata (entry_nxt),
    .re    (cmd.lookup),
    .raddr (slot),
    .rdata (rd_entry)
  );

  // Operation execute
  status_t     st;
  logic [31:0] oval;
  logic [31:0] omin;
  logic [31:0] omax;
  logic [31:0] oattr;
  logic        cnt_inc;
  logic        mode_ok;
  logic        out_of_range;
  rule_t       rule;

  assign mode_ok      = mode_r <= 3'(MODE_CLEAR);
  assign out_of_range = (value_r < $signed(rd_entry.lo)) || (value_r > $signed(rd_entry.hi));
  assign rule         = rule_t'(rd_entry.attr[RULE_MSB:RULE_LSB]);

  always_comb begin
    st        = ST_OK;
    oval      = '0;
    omin      = '0;
    omax      = '0;
    oattr     = '0;
    wr_en     = 1'b0;
    entry_nxt = rd_entry;
    cnt_inc   = 1'b0;
    if (mode_ok && !ok_r) begin
      st = ST_BAD_CODE;
    end else begin
      unique case (mode_t'(mode_r))
        MODE_LOAD: begin
          entry_nxt.live = value_r;
          entry_nxt.pers = value_r;
          entry_nxt.lo   = lmin_r;
          entry_nxt.hi   = lmax_r;
          entry_nxt.attr = lattr_r;
          wr_en          = 1'b1;
        end
        MODE_WRITE: begin
          if (out_of_range) begin
            st = ST_RANGE;
          end else begin
            case (rule) inside
              RULE_FREE, RULE_RUNLOCK: begin
                if (rule == RULE_RUNLOCK && run_r) begin
                  st = ST_BLOCKED;
                end else begin
                  entry_nxt.live = value_r;
                  entry_nxt.pers = value_r;
                  if (mark_r) entry_nxt.attr = rd_entry.attr | CHANGED_BIT;
                  wr_en = 1'b1;
                end
                cnt_inc = mark_r;
              end
              RULE_POWER: begin
                // persisted now, live only after power reset when marked
                st             = ST_POWER_RESET;
                entry_nxt.pers = value_r;
                if (mark_r) entry_nxt.attr = rd_entry.attr | CHANGED_BIT;
                else        entry_nxt.live = value_r;
                wr_en   = 1'b1;
                cnt_inc = mark_r;
              end
              RULE_RO: begin
                st = ST_READ_ONLY;
              end
              default: begin
                st = ST_READ_ONLY;
              end
            endcase
          end
        end
        MODE_READ: begin
          oval = rd_entry.pers;
          omin = rd_entry.lo;
          omax = rd_entry.hi;
        end
        MODE_LIVE: begin
          oval = rd_entry.live;
        end
        MODE_CLEAR: begin
          entry_nxt.attr = rd_entry.attr & CHANGED_CLEAR;
          wr_en          = 1'b1;
        end
        default: begin
          st = ST_OK;
        end
      endcase
      if (mode_ok) oattr = entry_nxt.attr;
    end
  end

  // Change counter
  logic [15:0] cnt_r;
  logic [15:0] cnt_nxt;

  assign cnt_nxt = cnt_r + 16'(cnt_inc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.execute) begin
      cnt_r <= cnt_nxt;
    end
  end

  // Result register
  logic out_valid_r;

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.execute) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      out_status       <= st;
      out_value        <= oval;
      out_min          <= omin;
      out_max          <= omax;
      out_attr         <= oattr;
      out_change_count <= cnt_nxt;
    end
  end

endmodule

// File: hdl/guarded_parameter_table.sv
// Guarded parameter table for a drive controller, one parameter store
// addressed by code: group = code / 100 (0, 50, 60, 100), index = code % 100.
//
// Channels: requests on in_* (valid/ready), one result per request on out_*
// (valid/ready). Modes: load entry, guarded write, read entry, read live
// value, clear changed bit. Bad codes give status 5 with zero data.
// Steps: an accepted request is captured, then decoded with the entry RAM
// read in the lookup state, then executed and written back in the execute state.
// No request is taken in the lookup state, a limit set by the read-modify-write of
// one entry through the registered-read entry RAM.
// The next request is taken in the execute cycle, so a pending result in
// the output register does not stall input unless the receiver holds off;
// while out_ready is low with a result waiting, the block finishes at most
// one more request up to execute and then holds in_ready low.
// Reset clears control state and the change counter; entries are undefined
// until loaded, and there is no clearing pass.
// Depends on gpt_pkg, gpt_ctrl, gpt_dpath, gpt_ram.
module guarded_parameter_table
  import gpt_pkg::*;
#(
  parameter int GROUP_A_SIZE = 64,
  parameter int GROUP_B_SIZE = 64,
  parameter int GROUP_C_SIZE = 64,
  parameter int GROUP_D_SIZE = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_mode,
  input  logic [15:0]        in_code,
  input  logic signed [31:0] in_new_value,
  input  logic signed [31:0] in_load_min,
  input  logic signed [31:0] in_load_max,
  input  logic [31:0]        in_load_attr,
  input  logic               in_mark_change,
  input  logic               in_drive_running,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic [31:0]        out_value,
  output logic signed [31:0] out_min,
  output logic signed [31:0] out_max,
  output logic [31:0]        out_attr,
  output logic [15:0]        out_change_count
);

  cmd_t cmd;
  sts_t sts;

  gpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gpt_dpath #(
    .GROUP_A_SIZE (GROUP_A_SIZE),
    .GROUP_B_SIZE (GROUP_B_SIZE),
    .GROUP_C_SIZE (GROUP_C_SIZE),
    .GROUP_D_SIZE (GROUP_D_SIZE)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_mode          (in_mode),
    .in_code          (in_code),
    .in_new_value     (in_new_value),
    .in_load_min      (in_load_min),
    .in_load_max      (in_load_max),
    .in_load_attr     (in_load_attr),
    .in_mark_change   (in_mark_change),
    .in_drive_running (in_drive_running),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_value        (out_value),
    .out_min          (out_min),
    .out_max          (out_max),
    .out_attr         (out_attr),
    .out_change_count (out_change_count)
  );

endmodule

// File: hdl/gpt_checker.sv
// Port-level checks for the guarded parameter table, bound to the top level.
// Depends on gpt_pkg and guarded_parameter_table.
module gpt_checker
  import gpt_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         out_status,
  input logic [31:0]        out_value,
  input logic signed [31:0] out_min,
  input logic signed [31:0] out_max,
  input logic [31:0]        out_attr,
  input logic [15:0]        out_change_count
);

  // No result left over from before reset
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_value)
      && $stable(out_attr) && $stable(out_change_count))
    else $error("stalled result changed");

  // An accepted request is followed by a lookup cycle with no new request taken
  a_one_per_two: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken in the lookup cycle");

  // A bad code returns no entry data
  a_bad_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == 3'(ST_BAD_CODE) |->
      out_value == '0 && out_min == '0 && out_max == '0 && out_attr == '0)
    else $error("bad code returned entry data");

  // Back-to-back results differ by at most one counted change
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready ##1 out_valid |->
      16'(out_change_count - $past(out_change_count)) <= 16'd1)
    else $error("change counter jumped");

endmodule

bind guarded_parameter_table gpt_checker u_gpt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_value        (out_value),
  .out_min          (out_min),
  .out_max          (out_max),
  .out_attr         (out_attr),
  .out_change_count (out_change_count)
);

// File: tb/parameter_table_checker.sv
`timescale 1ns / 100ps
// Checker for the guarded parameter table: watches both request and result
// channels, predicts every result and compares it field by field.
// Depends on gpt_pkg for modes, status codes, write rules and the entry layout.
module parameter_table_checker
  import gpt_pkg::*;
#(
  parameter int GROUP_A_SIZE = 64,
  parameter int GROUP_B_SIZE = 64,
  parameter int GROUP_C_SIZE = 64,
  parameter int GROUP_D_SIZE = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         in_mode,
  input  logic [15:0]        in_code,
  input  logic signed [31:0] in_new_value,
  input  logic signed [31:0] in_load_min,
  input  logic signed [31:0] in_load_max,
  input  logic [31:0]        in_load_attr,
  input  logic               in_mark_change,
  input  logic               in_drive_running,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [2:0]         out_status,
  input  logic [31:0]        out_value,
  input  logic signed [31:0] out_min,
  input  logic signed [31:0] out_max,
  input  logic [31:0]        out_attr,
  input  logic [15:0]        out_change_count,
  output int                 fail_count,
  output int                 pending
);

  localparam int CODES_PER_GROUP = 100;
  localparam int TABLE_DEPTH = GROUP_A_SIZE + GROUP_B_SIZE + GROUP_C_SIZE + GROUP_D_SIZE;

  typedef struct packed {
    status_t     status;
    logic [31:0] value;
    logic [31:0] min_val;
    logic [31:0] max_val;
    logic [31:0] attr;
    logic [15:0] count;
  } table_result_t;

  // Shadow copy of the table and the change counter
  entry_t        entries [TABLE_DEPTH];
  logic [15:0]   change_tally = '0;
  table_result_t expected_results [$];
  int            mismatches = 0;

  // Map a code to its table slot; 0 when the group or index does not exist
  function automatic bit lookup_slot(input logic [15:0] code, output int slot);
    int grp, idx, base, size;
    grp = code / CODES_PER_GROUP;
    idx = code % CODES_PER_GROUP;
    slot = 0;
    case (grp)
      GRP_A_NUM: begin base = 0; size = GROUP_A_SIZE; end
      GRP_B_NUM: begin base = GROUP_A_SIZE; size = GROUP_B_SIZE; end
      GRP_C_NUM: begin base = GROUP_A_SIZE + GROUP_B_SIZE; size = GROUP_C_SIZE; end
      GRP_D_NUM: begin
        base = GROUP_A_SIZE + GROUP_B_SIZE + GROUP_C_SIZE;
        size = GROUP_D_SIZE;
      end
      default: return 1'b0;
    endcase
    if (idx >= size) return 1'b0;
    slot = base + idx;
    return 1'b1;
  endfunction

  // Apply one request to the shadow table and return the result it causes
  function automatic table_result_t predict_access(
    input logic [2:0]         mode,
    input logic [15:0]        code,
    input logic signed [31:0] value,
    input logic signed [31:0] lmin,
    input logic signed [31:0] lmax,
    input logic [31:0]        lattr,
    input logic               mark,
    input logic               running
  );
    table_result_t r;
    entry_t        e;
    rule_t         rule;
    int            slot;
    r = '0;
    if (mode <= MODE_CLEAR) begin
      if (!lookup_slot(code, slot)) begin
        r.status = ST_BAD_CODE;
      end else begin
        e = entries[slot];
        case (mode)
          MODE_LOAD: begin
            e.live = value;
            e.pers = value;
            e.lo   = lmin;
            e.hi   = lmax;
            e.attr = lattr;
            r.attr = lattr;
          end
          MODE_WRITE: begin
            // limits first; a value outside them changes nothing
            if (value < $signed(e.lo) || value > $signed(e.hi)) begin
              r.status = ST_RANGE;
            end else begin
              rule = rule_t'(e.attr[RULE_MSB:RULE_LSB]);
              case (rule) inside
                RULE_FREE, RULE_RUNLOCK: begin
                  if (rule == RULE_RUNLOCK && running) begin
                    r.status = ST_BLOCKED;
                  end else begin
                    e.live = value;
                    e.pers = value;
                    if (mark) e.attr |= CHANGED_BIT;
                  end
                end
                RULE_POWER: begin
                  // marked: live value waits for the next power cycle
                  e.pers = value;
                  if (mark) e.attr |= CHANGED_BIT;
                  else e.live = value;
                  r.status = ST_POWER_RESET;
                end
                default: r.status = ST_READ_ONLY;
              endcase
              // a blocked write still counts as a change
              if (mark && r.status != ST_READ_ONLY) change_tally++;
            end
            r.attr = e.attr;
          end
          MODE_READ: begin
            r.value   = e.pers;
            r.min_val = e.lo;
            r.max_val = e.hi;
            r.attr    = e.attr;
          end
          MODE_LIVE: begin
            r.value = e.live;
            r.attr  = e.attr;
          end
          default: begin
            e.attr &= CHANGED_CLEAR;
            r.attr = e.attr;
          end
        endcase
        entries[slot] = e;
      end
    end
    r.count = change_tally;
    return r;
  endfunction

  function automatic int field_differs(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Results are checked before the request of the same edge is predicted;
  // a request never produces its result at the edge it is accepted.
  always @(posedge clk) begin : monitor
    table_result_t got, want;
    if (!rst_n) begin
      change_tally = '0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        got.status  = status_t'(out_status);
        got.value   = out_value;
        got.min_val = out_min;
        got.max_val = out_max;
        got.attr    = out_attr;
        got.count   = out_change_count;
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          mismatches += field_differs("status", want.status, got.status);
          mismatches += field_differs("value", want.value, got.value);
          mismatches += field_differs("min", want.min_val, got.min_val);
          mismatches += field_differs("max", want.max_val, got.max_val);
          mismatches += field_differs("attr", want.attr, got.attr);
          mismatches += field_differs("change_count", want.count, got.count);
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(predict_access(in_mode, in_code, in_new_value,
          in_load_min, in_load_max, in_load_attr, in_mark_change, in_drive_running));
    end
    pending    <= expected_results.size();
    fail_count <= mismatches;
  end

endmodule

// File: tb/guarded_parameter_table_tb.sv
`timescale 1ns / 100ps
// Testbench top for the guarded parameter table: clock, reset, request
// stimulus, result back-pressure, watchdog and verdict.
// Depends on gpt_pkg, guarded_parameter_table and parameter_table_checker.
module guarded_parameter_table_tb;
  import gpt_pkg::*;

  localparam int GROUP_SIZE      = 64;
  localparam int CODES_PER_GROUP = 100;
  localparam int RANDOM_REQUESTS = 2000;
  localparam int STALL_LIMIT     = 5000;
  localparam int DRAIN_CYCLES    = 10;
  localparam int MODE_MAX        = 7;   // largest 3-bit mode code

  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;

  // First and last entries of the groups used by the directed requests
  localparam logic [15:0] CODE_A_FIRST = 16'(GRP_A_NUM * CODES_PER_GROUP);
  localparam logic [15:0] CODE_A_LAST  = 16'(GRP_A_NUM * CODES_PER_GROUP + GROUP_SIZE - 1);
  localparam logic [15:0] CODE_B_FIRST = 16'(GRP_B_NUM * CODES_PER_GROUP);
  localparam logic [15:0] CODE_C_LAST  = 16'(GRP_C_NUM * CODES_PER_GROUP + GROUP_SIZE - 1);
  localparam logic [15:0] CODE_D_LAST  = 16'(GRP_D_NUM * CODES_PER_GROUP + GROUP_SIZE - 1);

  typedef struct {
    logic [2:0]         mode;
    logic [15:0]        code;
    logic signed [31:0] value;
    logic signed [31:0] lmin;
    logic signed [31:0] lmax;
    logic [31:0]        attr;
    logic               mark;
    logic               running;
  } request_t;

  logic               clk              = 1'b0;
  logic               rst_n            = 1'b0;
  logic               in_valid         = 1'b0;
  logic [2:0]         in_mode          = '0;
  logic [15:0]        in_code          = '0;
  logic signed [31:0] in_new_value     = '0;
  logic signed [31:0] in_load_min      = '0;
  logic signed [31:0] in_load_max      = '0;
  logic [31:0]        in_load_attr     = '0;
  logic               in_mark_change   = 1'b0;
  logic               in_drive_running = 1'b0;
  logic               out_ready        = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic [2:0]         out_status;
  logic [31:0]        out_value;
  logic signed [31:0] out_min;
  logic signed [31:0] out_max;
  logic [31:0]        out_attr;
  logic [15:0]        out_change_count;
  int                 fail_count;
  int                 pending;

  int send_idle_pct = 30;
  int recv_idle_pct = 45;
  int issued        = 0;
  int stall_cycles  = 0;

  // Entries loaded so far, with the limits they were given
  logic [15:0] loaded_codes [$];
  int          lo_of [int];
  int          hi_of [int];

  guarded_parameter_table #(
    .GROUP_A_SIZE(GROUP_SIZE), .GROUP_B_SIZE(GROUP_SIZE),
    .GROUP_C_SIZE(GROUP_SIZE), .GROUP_D_SIZE(GROUP_SIZE)
  ) dut (.*);

  parameter_table_checker #(
    .GROUP_A_SIZE(GROUP_SIZE), .GROUP_B_SIZE(GROUP_SIZE),
    .GROUP_C_SIZE(GROUP_SIZE), .GROUP_D_SIZE(GROUP_SIZE)
  ) checker_i (.*);

  always #5 clk = ~clk;

  // Result back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog: too long without any request or result moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Present one request, with random idle cycles ahead of it
  task automatic issue(input request_t q);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= q.mode;
    in_code          <= q.code;
    in_new_value     <= q.value;
    in_load_min      <= q.lmin;
    in_load_max      <= q.lmax;
    in_load_attr     <= q.attr;
    in_mark_change   <= q.mark;
    in_drive_running <= q.running;
    do @(posedge clk); while (!in_ready);
    issued++;
  endtask

  // Request with every field the mode ignores filled at random
  function automatic request_t blank_request(input logic [2:0] mode, input logic [15:0] code);
    request_t q;
    q.mode    = mode;
    q.code    = code;
    q.value   = $urandom;
    q.lmin    = $urandom;
    q.lmax    = $urandom;
    q.attr    = $urandom;
    q.mark    = $urandom_range(0, 1);
    q.running = $urandom_range(0, 1);
    return q;
  endfunction

  function automatic logic [31:0] rule_attr(input rule_t rule);
    return 32'(rule) << RULE_LSB;
  endfunction

  task automatic load_entry(input logic [15:0] code, input logic signed [31:0] value,
                            input logic signed [31:0] lo, input logic signed [31:0] hi,
                            input logic [31:0] attr);
    request_t q;
    q      = blank_request(MODE_LOAD, code);
    q.value = value;
    q.lmin = lo;
    q.lmax = hi;
    q.attr = attr;
    issue(q);
    if (!lo_of.exists(code)) loaded_codes.push_back(code);
    lo_of[code] = lo;
    hi_of[code] = hi;
  endtask

  task automatic send_write(input logic [15:0] code, input logic signed [31:0] value,
                            input logic mark, input logic running);
    request_t q;
    q         = blank_request(MODE_WRITE, code);
    q.value   = value;
    q.mark    = mark;
    q.running = running;
    issue(q);
  endtask

  task automatic send_op(input logic [2:0] mode, input logic [15:0] code);
    issue(blank_request(mode, code));
  endtask

  function automatic logic [15:0] valid_code();
    int grp;
    case ($urandom_range(0, 3))
      0:       grp = GRP_A_NUM;
      1:       grp = GRP_B_NUM;
      2:       grp = GRP_C_NUM;
      default: grp = GRP_D_NUM;
    endcase
    return 16'(grp * CODES_PER_GROUP + $urandom_range(0, GROUP_SIZE - 1));
  endfunction

  // Either an index past the end of a real group or a group that does not exist
  function automatic logic [15:0] bad_code();
    logic [15:0] c;
    int grp;
    if ($urandom_range(0, 1)) begin
      c = valid_code();
      c = 16'(c - c % CODES_PER_GROUP + $urandom_range(GROUP_SIZE, CODES_PER_GROUP - 1));
      return c;
    end
    do begin
      c   = 16'($urandom_range(0, 65535));
      grp = c / CODES_PER_GROUP;
    end while (grp == GRP_A_NUM || grp == GRP_B_NUM || grp == GRP_C_NUM || grp == GRP_D_NUM);
    return c;
  endfunction

  function automatic logic [15:0] known_code();
    return loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
  endfunction

  // Mostly inside the limits, some on and just past them, some anywhere
  function automatic logic signed [31:0] write_value(input logic [15:0] code);
    longint lo, hi, span;
    longint unsigned r64;
    lo  = lo_of[code];
    hi  = hi_of[code];
    r64 = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        if (lo > hi) return $urandom;
        span = hi - lo + 1;
        return 32'(lo + longint'(r64 % unsigned'(span)));
      end
      4:       return 32'(lo);
      5:       return 32'(hi);
      6:       return 32'(lo - 1);
      7:       return 32'(hi + 1);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_limits(output int lo, output int hi);
    int a, b, width;
    longint top;
    a = $urandom;
    b = $urandom;
    case ($urandom_range(0, 9))
      0: begin lo = S32_MIN; hi = S32_MAX; end
      // inverted limits: every write is out of range
      1: begin lo = (a > b) ? a : b; hi = (a > b) ? b : a; end
      2, 3, 4, 5: begin
        width = $urandom_range(0, 1000);
        top   = longint'(a) + width;
        lo    = a;
        hi    = (top > S32_MAX) ? S32_MAX : int'(top);
      end
      default: begin lo = (a < b) ? a : b; hi = (a < b) ? b : a; end
    endcase
  endtask

  task automatic random_request();
    int pick, lo, hi;
    logic [15:0] code;
    request_t q;
    pick = $urandom_range(0, 99);
    if (loaded_codes.size() == 0 || pick < 15) begin
      random_limits(lo, hi);
      load_entry(valid_code(), $urandom, lo, hi, $urandom);
    end else if (pick < 55) begin
      code    = known_code();
      q       = blank_request(MODE_WRITE, code);
      q.value = write_value(code);
      issue(q);
    end else if (pick < 68) begin
      send_op(MODE_READ, known_code());
    end else if (pick < 78) begin
      send_op(MODE_LIVE, known_code());
    end else if (pick < 88) begin
      send_op(MODE_CLEAR, known_code());
    end else if (pick < 94) begin
      send_op(3'($urandom_range(int'(MODE_LOAD), int'(MODE_CLEAR))), bad_code());
    end else begin
      send_op(3'($urandom_range(int'(MODE_CLEAR) + 1, MODE_MAX)),
              $urandom_range(0, 1) ? known_code() : bad_code());
    end
  endtask

  initial begin
    int directed;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: one entry per write rule, group ends, limit edges
    load_entry(CODE_A_FIRST, 32'sd0, S32_MIN, S32_MAX, rule_attr(RULE_FREE));
    load_entry(CODE_A_LAST, -32'sd1, -32'sd100, 32'sd100, rule_attr(RULE_RUNLOCK));
    load_entry(CODE_B_FIRST, 32'sd7, 32'sd0, 32'sd1000, rule_attr(RULE_POWER));
    load_entry(CODE_C_LAST, 32'sd3, S32_MIN, S32_MAX, 32'hFFFF_FFFF);
    load_entry(CODE_D_LAST, 32'sd42, 32'sd42, 32'sd42, 32'hFFFF_FEE7);
    send_write(CODE_A_FIRST, S32_MAX, 1'b1, 1'b1);
    send_write(CODE_A_FIRST, S32_MIN, 1'b0, 1'b0);
    send_write(CODE_A_LAST, 32'sd101, 1'b1, 1'b0);
    send_write(CODE_A_LAST, -32'sd101, 1'b0, 1'b0);
    send_write(CODE_A_LAST, 32'sd100, 1'b1, 1'b1);
    send_write(CODE_A_LAST, -32'sd100, 1'b1, 1'b0);
    send_write(CODE_B_FIRST, 32'sd500, 1'b1, 1'b1);
    send_op(MODE_READ, CODE_B_FIRST);
    send_op(MODE_LIVE, CODE_B_FIRST);
    send_write(CODE_B_FIRST, 32'sd0, 1'b0, 1'b0);
    send_write(CODE_C_LAST, 32'sd5, 1'b1, 1'b0);
    send_write(CODE_D_LAST, 32'sd42, 1'b1, 1'b1);
    send_write(CODE_D_LAST, 32'sd43, 1'b1, 1'b0);
    send_op(MODE_CLEAR, CODE_A_FIRST);
    send_op(MODE_READ, CODE_A_LAST);
    // bad codes: indexes past a group and groups that do not exist
    send_op(MODE_READ, CODE_A_LAST + 16'd1);
    send_op(MODE_WRITE, 16'(CODE_A_FIRST + CODES_PER_GROUP - 1));
    send_op(MODE_LIVE, 16'(CODES_PER_GROUP));
    send_op(MODE_LOAD, 16'hFFFF);
    send_op(MODE_CLEAR, 16'(GRP_D_NUM * CODES_PER_GROUP + CODES_PER_GROUP - 1));
    // modes beyond the defined set
    send_op(3'(int'(MODE_CLEAR) + 1), CODE_A_FIRST);
    send_op(3'(MODE_MAX), CODE_B_FIRST);
    directed = issued;

    // Random: receiver-heavy idling, then sender-heavy, then none
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 45 : 0;
      recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 30 : 0;
      for (int i = 0; i < RANDOM_REQUESTS / 3; i++) random_request();
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d directed) across three idle/back-pressure phases.",
             issued, directed);
    $display("Touched %0d table entries in all four groups, plus bad codes and unused modes.",
             loaded_codes.size());
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
